// File: hw/rtl/bsm_pkg.sv
// Package: widths and stage type for the radix-2 Booth multiplier.
package bsm_pkg;

    localparam int WIDTH     = 4;
    localparam int PROD_W    = 2 * WIDTH - 1;
    localparam int S_TDATA_W = ((2 * WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W = ((PROD_W + 7) / 8) * 8;
    localparam int STAGES    = WIDTH + 1;

    typedef struct packed {
        logic [WIDTH-1:0] acc;
        logic [WIDTH-1:0] q;
        logic [WIDTH-1:0] m;
        logic             prev;
    } bsm_stage_t;

endpackage

// File: hw/rtl/booth_signed_multiplier.sv
// Each input transaction is registered in stage 0, then in each Booth stage in turn; the last stage holds the result.
// Throughput: one transaction per cycle unless m_tready stalls the output; one Booth step in each stage after stage 0.
// Each stage advances when the stage after it is empty or moving, so stalls lose nothing.
// Reset: aresetn synchronous, active low; clears all stage valid bits, data is not reset.
// Top level: pipelined radix-2 Booth signed multiplier with stream ports.
module booth_signed_multiplier (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [3:0] multiplicand, [7:4] multiplier
    input  logic [bsm_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [6:0] product, upper bits zero
    output logic [bsm_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int W = bsm_pkg::WIDTH;
    localparam int N = bsm_pkg::STAGES;

    logic [N-1:0]       valid_reg;
    logic [N-1:0]       valid_next;
    logic [N-1:0]       rdy;
    bsm_pkg::bsm_stage_t stage_reg  [N];
    bsm_pkg::bsm_stage_t stage_next [N];
    logic [2*W-1:0]     full_prod;

    // ready chain, last stage first
    always_comb begin
        rdy[N-1] = !valid_reg[N-1] || m_tready;
        for (int j = N - 2; j >= 0; j--) begin
            rdy[j] = !valid_reg[j] || rdy[j+1];
        end
    end

    // stage 0 captures operands, stage j performs Booth step j
    always_comb begin
        logic [W-1:0] a;
        stage_next[0].acc  = '0;
        stage_next[0].prev = 1'b0;
        stage_next[0].m    = s_tdata[W-1:0];
        stage_next[0].q    = s_tdata[2*W-1:W];
        valid_next[0]      = s_tvalid;
        for (int j = 1; j < N; j++) begin
            a = stage_reg[j-1].acc;
            if (stage_reg[j-1].q[0] && !stage_reg[j-1].prev) begin
                a = stage_reg[j-1].acc - stage_reg[j-1].m;
            end else if (!stage_reg[j-1].q[0] && stage_reg[j-1].prev) begin
                a = stage_reg[j-1].acc + stage_reg[j-1].m;
            end
            stage_next[j].m    = stage_reg[j-1].m;
            stage_next[j].prev = stage_reg[j-1].q[0];
            stage_next[j].q    = {a[0], stage_reg[j-1].q[W-1:1]};
            stage_next[j].acc  = {a[W-1], a[W-1:1]};
            valid_next[j]      = valid_reg[j-1];
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < N; j++) begin
            if (!aresetn) begin
                valid_reg[j] <= 1'b0;
            end else if (rdy[j]) begin
                valid_reg[j] <= valid_next[j];
            end
            if (rdy[j]) begin
                stage_reg[j] <= stage_next[j];
            end
        end
    end

    assign full_prod = {stage_reg[N-1].acc, stage_reg[N-1].q};
    assign s_tready  = rdy[0];
    assign m_tvalid  = valid_reg[N-1];
    assign m_tdata   = {{(bsm_pkg::M_TDATA_W - bsm_pkg::PROD_W){1'b0}},
                        full_prod[bsm_pkg::PROD_W-1:0]};

    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (&valid_reg))
        else $error("input blocked while pipeline has a free stage");

    a_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |->
        ($countones(valid_reg) == $countones($past(valid_reg))
            + int'($past(s_tvalid && s_tready)) - int'($past(m_tvalid && m_tready))))
        else $error("transaction lost or duplicated in pipeline");

    a_mcand_travels: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[0] && rdy[1]) |=> (stage_reg[1].m == $past(stage_reg[0].m)))
        else $error("multiplicand corrupted between stages");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[N-1] && !m_tready) |=> (valid_reg[N-1] && $stable(full_prod)))
        else $error("stalled result changed");

endmodule
